// ----- src/scpr_pkg.sv -----
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared sizes for the second-chance page replacer.
// ----------------------------------------------------------------------------
package scpr_pkg;

    // Table size and field widths
    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int TOTAL_W    = 32;

    // Stream payload widths
    localparam int IN_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + 4 + 1 + PAGE_BITS + TOTAL_W + TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

endpackage

// ----- src/scpr_ram.sv -----
// ----------------------------------------------------------------------------
// scpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/second_chance_page_replacer_core.sv -----
// ----------------------------------------------------------------------------
// second_chance_page_replacer_core
// Clock (second-chance) page replacement over a table of page frames.
// ----------------------------------------------------------------------------
// One input beat is one page reference; one output beat follows for each. The
// page numbers live in a small RAM with one read port, so the lookup visits
// the filled frames one at a time, reading and then comparing each one. A
// miss fills a free frame if one is left; when the table is full the clock hand
// sweeps one frame per cycle (at most frames_in_use + 1 steps), then reads
// out and replaces the victim. The next reference is taken as soon as the
// result is loaded into the output register, even if that beat is not yet
// taken. frames_in_use is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, and the block itself does not enforce this.
// 0 acts as 1 and values above 16 act as 16.
// ----------------------------------------------------------------------------
module second_chance_page_replacer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: frames_in_use
    input  logic                                 cfg_wr_en,
    input  logic [scpr_pkg::CFG_W-1:0]           cfg_wr_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [scpr_pkg::IN_TDATA_W-1:0]      s_tdata,  // page_number
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit, frame_index, evicted_valid, evicted_page, fault_count, reference_count
    output logic [scpr_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int FW = scpr_pkg::FRAME_W;
    localparam int CW = scpr_pkg::COUNT_W;
    localparam int PW = scpr_pkg::PAGE_BITS;
    localparam int TW = scpr_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [scpr_pkg::CFG_W-1:0]    frames_cfg_reg;
    logic [PW-1:0]                 page_reg;
    logic [CW-1:0]                 n_reg;
    logic [CW-1:0]                 limit_reg;
    logic [FW-1:0]                 idx_reg;
    logic [FW-1:0]                 hand_reg;
    logic [FW-1:0]                 sweep_reg;
    logic [CW-1:0]                 filled_reg;
    logic [scpr_pkg::MAX_FRAMES-1:0] valid_reg;
    logic [scpr_pkg::MAX_FRAMES-1:0] refbit_reg;
    logic [TW-1:0]                 faults_reg;
    logic [TW-1:0]                 refs_reg;
    logic                          hit_reg;
    logic [FW-1:0]                 frame_reg;
    logic                          ev_valid_reg;
    logic [PW-1:0]                 ev_page_reg;
    logic                          m_tvalid_reg;
    logic [scpr_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic [CW-1:0] n_act;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] sweep_inc;
    logic [FW-1:0] sweep_wrap;
    logic          in_beat;
    logic          out_free;

    // RAM ports
    logic          ram_we;
    logic [FW-1:0] ram_waddr;
    logic [FW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;

    // Effective frame count: clamp to 1..MAX_FRAMES
    always_comb begin
        if (frames_cfg_reg == '0) begin
            n_act = CW'(1);
        end else if (32'(frames_cfg_reg) > 32'(scpr_pkg::MAX_FRAMES)) begin
            n_act = CW'(scpr_pkg::MAX_FRAMES);
        end else begin
            n_act = CW'(frames_cfg_reg);
        end
    end

    assign in_beat    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign sweep_inc  = CW'(sweep_reg) + CW'(1);
    assign sweep_wrap = (sweep_inc == n_reg) ? '0 : sweep_inc[FW-1:0];

    // Page RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = filled_reg[FW-1:0];
        ram_raddr = idx_reg;
        unique case (state_reg)
            ST_MISS: begin
                ram_we    = (filled_reg < n_reg);
                ram_waddr = filled_reg[FW-1:0];
            end
            ST_SWEEP: begin
                ram_raddr = sweep_reg;
            end
            ST_EVICT: begin
                ram_we    = 1'b1;
                ram_waddr = frame_reg;
            end
            default: begin
            end
        endcase
    end

    scpr_ram #(
        .WIDTH(PW),
        .DEPTH(scpr_pkg::MAX_FRAMES)
    ) u_page_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(page_reg),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Control sequencer, frame bits and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frames_cfg_reg <= scpr_pkg::FRAMES_RESET;
            filled_reg     <= '0;
            hand_reg       <= '0;
            valid_reg      <= '0;
            refbit_reg     <= '0;
            faults_reg     <= '0;
            refs_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frames_cfg_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        page_reg     <= s_tdata[PW-1:0];
                        n_reg        <= n_act;
                        limit_reg    <= (filled_reg < n_act) ? filled_reg : n_act;
                        idx_reg      <= '0;
                        hit_reg      <= 1'b0;
                        ev_valid_reg <= 1'b0;
                        ev_page_reg  <= '0;
                        refs_reg     <= (refs_reg == '1) ? refs_reg : refs_reg + TW'(1);
                        state_reg    <= (filled_reg == '0) ? ST_MISS : ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (valid_reg[idx_reg] && ram_rdata == page_reg) begin
                        hit_reg             <= 1'b1;
                        frame_reg           <= idx_reg;
                        refbit_reg[idx_reg] <= 1'b1;
                        state_reg           <= ST_DONE;
                    end else if (idx_inc >= limit_reg) begin
                        state_reg <= ST_MISS;
                    end else begin
                        idx_reg   <= idx_inc[FW-1:0];
                        state_reg <= ST_READ;
                    end
                end
                ST_MISS: begin
                    faults_reg <= (faults_reg == '1) ? faults_reg : faults_reg + TW'(1);
                    if (filled_reg < n_reg) begin
                        // Free frame left: fill it, hand stays put
                        frame_reg                      <= filled_reg[FW-1:0];
                        valid_reg[filled_reg[FW-1:0]]  <= 1'b1;
                        refbit_reg[filled_reg[FW-1:0]] <= 1'b0;
                        filled_reg                     <= filled_reg + CW'(1);
                        state_reg                      <= ST_DONE;
                    end else begin
                        sweep_reg <= (CW'(hand_reg) < n_reg) ? hand_reg : '0;
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    // Give set frames a second chance; stop on the first clear one
                    if (refbit_reg[sweep_reg]) begin
                        refbit_reg[sweep_reg] <= 1'b0;
                        sweep_reg             <= sweep_wrap;
                    end else begin
                        frame_reg <= sweep_reg;
                        hand_reg  <= sweep_wrap;
                        state_reg <= ST_EVICT;
                    end
                end
                ST_EVICT: begin
                    ev_valid_reg          <= valid_reg[frame_reg];
                    ev_page_reg           <= valid_reg[frame_reg] ? ram_rdata : '0;
                    valid_reg[frame_reg]  <= 1'b1;
                    refbit_reg[frame_reg] <= 1'b0;
                    state_reg             <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= scpr_pkg::OUT_TDATA_W'({refs_reg, faults_reg, ev_page_reg,
                                                   ev_valid_reg, 4'(frame_reg), hit_reg});
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
